[design/mvm_pkg.sv]
package mvm_pkg;

   localparam int MAX_LENGTH  = 32;
   localparam int COL_W       = $clog2(MAX_LENGTH);
   localparam int LEN_W       = 6;
   localparam int CMP_W       = (COL_W + 1 > LEN_W) ? COL_W + 1 : LEN_W;
   localparam int LEN_RESET   = 20;
   localparam int IDX_W       = 5;
   localparam int VAL_W       = 16;
   localparam int PROD_W      = 2 * VAL_W;
   localparam int ACC_W       = 40;
   localparam int ROW_W       = 10;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic CMD_VECTOR_WRITE = 1'b0;
   localparam logic CMD_MATRIX_ELEM  = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [IDX_W-1:0]  vector_index;
      logic [VAL_W-1:0]  element_value;
   } req_type;

   typedef struct packed {
      logic [ACC_W-1:0]  dot_product;
      logic [ROW_W-1:0]  row_number;
   } rsp_type;

   // one multiply-accumulate job, handed from front to back
   typedef struct packed {
      logic [VAL_W-1:0]  matrix_value;
      logic [VAL_W-1:0]  vector_value;
      logic              last;
      logic [ROW_W-1:0]  row;
   } op_type;

   typedef struct packed {
      logic    valid;
      op_type  op;
   } push_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              empty;
   } queue_status_type;

endpackage

[design/matrix_vector_multiply_core.sv]
// Matrix-vector multiply, c = A*b, in Q7.8 fixed point.
//
// Request channel (req_valid / req_stall / req_data): cmd 0 writes one vector
// element into the vector store; cmd 1 streams one matrix element, row-major.
// A request is taken on any edge where req_valid is high and req_stall low.
// Response channel (rsp_valid / rsp_stall / rsp_data): one response per
// finished row, carrying the 40-bit Q23.16 dot product (wraps) and the row
// number modulo 1024.
// csr_valid / csr_ready / csr_data writes vector_length; csr_ready is always
// high. Write it only while the block is idle.
//
// Throughput: one request per cycle while req_stall stays low. The front end
// reads the vector store and queues a multiply-accumulate op; the back end pops
// one op a cycle through the multiply stage and the accumulator while the
// queue holds an op and no stalled response holds the back end.
// Reset clears counters, accumulator and queue and sets vector_length to 20;
// the vector store holds garbage until written. When rsp_stall holds the
// response, the back end freezes, the 4-entry queue fills and req_stall rises.
module matrix_vector_multiply_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mvm_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mvm_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [mvm_pkg::LEN_W-1:0] csr_data
);
   import mvm_pkg::*;

   push_type         push;
   op_type           head;
   queue_status_type q_status;
   logic             pop;

   // register writes are never held off
   assign csr_ready = 1'b1;

   // front: request intake, vector store, column and row tracking
   mvm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .push      (push)
   );

   // decouples intake from the MAC so each side stalls on its own
   mvm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (q_status)
   );

   // back: multiply, accumulate, response register
   mvm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[design/mvm_front.sv]
module mvm_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mvm_pkg::req_type         req_data,
   input  logic                     csr_valid,
   input  logic [mvm_pkg::LEN_W-1:0] csr_data,
   input  mvm_pkg::queue_status_type q_status,
   output mvm_pkg::push_type        push
);
   import mvm_pkg::*;

   logic [VAL_W-1:0] vstore [MAX_LENGTH];

   logic [LEN_W-1:0] len_ff, len_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             s1_valid_ff, s1_valid_in;
   logic [VAL_W-1:0] s1_mat_ff;
   logic [VAL_W-1:0] s1_vec_ff;
   logic             s1_last_ff;
   logic [ROW_W-1:0] s1_row_ff;

   logic             accept;
   logic             mat_accept;
   logic             vec_write;
   logic [CMP_W-1:0] len_ext;
   logic [CMP_W-1:0] act_len;
   logic             row_end;

   // room for the staged op plus one more
   assign req_stall = (CMP_W'(q_status.count) + CMP_W'(s1_valid_ff)) >= CMP_W'(QUEUE_DEPTH);

   assign accept     = req_valid && !req_stall;
   assign mat_accept = accept && (req_data.cmd == CMD_MATRIX_ELEM);
   assign vec_write  = accept && (req_data.cmd == CMD_VECTOR_WRITE) &&
                       (CMP_W'(req_data.vector_index) < CMP_W'(MAX_LENGTH));

   // length 0 acts as 1, too large saturates
   always_comb begin
      len_ext = CMP_W'(len_ff);
      if (len_ext == '0) begin
         act_len = CMP_W'(1);
      end else if (len_ext > CMP_W'(MAX_LENGTH)) begin
         act_len = CMP_W'(MAX_LENGTH);
      end else begin
         act_len = len_ext;
      end
   end

   assign row_end = (CMP_W'(col_ff) + CMP_W'(1)) >= act_len;

   always_comb begin
      len_in      = csr_valid ? csr_data : len_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = mat_accept;
      if (mat_accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff      <= LEN_W'(LEN_RESET);
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         len_ff      <= len_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vec_write) begin
         vstore[COL_W'(req_data.vector_index)] <= req_data.element_value;
      end
      if (mat_accept) begin
         s1_vec_ff  <= vstore[col_ff];
         s1_mat_ff  <= req_data.element_value;
         s1_last_ff <= row_end;
         s1_row_ff  <= row_ff;
      end
   end

   assign push.valid           = s1_valid_ff;
   assign push.op.matrix_value = s1_mat_ff;
   assign push.op.vector_value = s1_vec_ff;
   assign push.op.last         = s1_last_ff;
   assign push.op.row          = s1_row_ff;

endmodule

[design/mvm_queue.sv]
module mvm_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  mvm_pkg::push_type         push,
   input  logic                      pop,
   output mvm_pkg::op_type           head,
   output mvm_pkg::queue_status_type status
);
   import mvm_pkg::*;

   op_type            slots [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push.valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push.valid) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         slots[wr_ptr_ff] <= push.op;
      end
   end

   assign head         = slots[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = (count_ff == '0);

endmodule

[design/mvm_back.sv]
module mvm_back (
   input  logic                      clock,
   input  logic                      reset,
   input  mvm_pkg::op_type           head,
   input  mvm_pkg::queue_status_type q_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mvm_pkg::rsp_type          rsp_data
);
   import mvm_pkg::*;

   logic                     m_valid_ff, m_valid_in;
   logic signed [PROD_W-1:0] m_prod_ff;
   logic                     m_last_ff;
   logic [ROW_W-1:0]         m_row_ff;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic                     out_valid_ff, out_valid_in;
   rsp_type                  out_data_ff;

   logic                     advance;
   logic [ACC_W-1:0]         acc_sum;

   // whole back end holds while a result sits stalled
   assign advance = !out_valid_ff || !rsp_stall;
   assign pop     = advance && !q_status.empty;

   // Q7.8 x Q7.8 is exact Q15.16; sign-extend into the wrapping accumulator
   assign acc_sum = acc_ff + ACC_W'(m_prod_ff);

   always_comb begin
      m_valid_in   = m_valid_ff;
      acc_in       = acc_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         m_valid_in   = pop;
         out_valid_in = m_valid_ff && m_last_ff;
         if (m_valid_ff) begin
            acc_in = m_last_ff ? '0 : acc_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         acc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= m_valid_in;
         acc_ff       <= acc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         m_prod_ff <= $signed(head.matrix_value) * $signed(head.vector_value);
         m_last_ff <= head.last;
         m_row_ff  <= head.row;
      end
      if (advance && m_valid_ff && m_last_ff) begin
         out_data_ff.dot_product <= acc_sum;
         out_data_ff.row_number  <= m_row_ff;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[design/mvm_checker.sv]
module mvm_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_stall,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  mvm_pkg::rsp_type rsp_data
);
   import mvm_pkg::*;

   logic [ROW_W-1:0] exp_row_ff, exp_row_in;

   assign exp_row_in = (rsp_valid && !rsp_stall) ? exp_row_ff + ROW_W'(1) : exp_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_row_ff <= '0;
      end else begin
         exp_row_ff <= exp_row_in;
      end
   end

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("request stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_row_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.row_number == exp_row_ff)
      else $error("row number out of sequence");

endmodule

bind matrix_vector_multiply_core mvm_checker u_checker (.*);

[dv/matrix_vector_multiply_core_test.sv]
module matrix_vector_multiply_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mvm_pkg::*;

   localparam int CLOCK_HALF     = 5;
   localparam int RESET_CYCLES   = 10;
   localparam int RANDOM_ITEMS   = 550;
   // pipeline drain margin after the last row is back; give it some slack
   localparam int DRAIN_CYCLES   = 8;
   localparam int MAX_WAIT       = 19;
   localparam int HOLD_CYCLES    = 200;
   localparam int REPORT_LIMIT   = 10;
   // above the longest quiet span of a good run: hold-off + stall + gap + pipeline
   localparam int WATCHDOG_LIMIT = 2000;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_type          req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_type          rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_data  = '0;

   matrix_vector_multiply_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Dot product predictor: a private copy of the vector store, the running
   // row sum and the counters. Updated on every accepted request.
   // ---------------------------------------------------------------------
   logic signed [VAL_W-1:0] vector_copy [MAX_LENGTH];
   logic [ACC_W-1:0]        row_sum    = '0;
   int unsigned             column_pos = 0;
   logic [ROW_W-1:0]        row_count  = '0;
   logic [LEN_W-1:0]        length_reg = LEN_W'(LEN_RESET);
   rsp_type                 expected_rows [$];

   // length 0 behaves as 1, anything past the store depth saturates
   function automatic int unsigned effective_length(logic [LEN_W-1:0] value);
      if (value == '0)
         return 1;
      if (value > MAX_LENGTH)
         return MAX_LENGTH;
      return value;
   endfunction

   task automatic accumulate_request(req_type r);
      int unsigned             col;
      logic signed [PROD_W-1:0] product;
      rsp_type                 row;
      // vector write: store only, counters and sum untouched
      if (r.cmd == CMD_VECTOR_WRITE) begin
         vector_copy[r.vector_index] = r.element_value;
         return;
      end
      col = (column_pos >= MAX_LENGTH) ? MAX_LENGTH - 1 : column_pos;
      // exact Q15.16 product, sign extended into the 40-bit wrapping sum
      product = $signed(r.element_value) * vector_copy[col];
      row_sum = row_sum + {{(ACC_W-PROD_W){product[PROD_W-1]}}, product};
      // a counter at or past the last column (length lowered mid-row)
      // closes the row right away
      if (column_pos + 1 >= effective_length(length_reg)) begin
         row.dot_product = row_sum;
         row.row_number  = row_count;
         expected_rows.push_back(row);
         row_sum    = '0;
         column_pos = 0;
         row_count  = row_count + 1'b1;
      end else begin
         column_pos++;
      end
   endtask

   // ---------------------------------------------------------------------
   // Request planning. Tracks the column each queued matrix element will hit
   // so that no store entry is read before it has been written.
   // ---------------------------------------------------------------------
   req_type               pending_requests [$];
   int unsigned           queued_total = 0;
   int unsigned           plan_column  = 0;
   int unsigned           plan_length  = LEN_RESET;
   logic [MAX_LENGTH-1:0] plan_written = '0;

   function automatic logic [VAL_W-1:0] draw_value();
      case ($urandom_range(0, 7))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   task automatic queue_vector_write(int unsigned idx, logic [VAL_W-1:0] value);
      req_type r;
      r.cmd           = CMD_VECTOR_WRITE;
      r.vector_index  = IDX_W'(idx);
      r.element_value = value;
      pending_requests.push_back(r);
      queued_total++;
      plan_written[idx] = 1'b1;
   endtask

   task automatic queue_matrix_element(logic [VAL_W-1:0] value);
      req_type     r;
      int unsigned col;
      col = (plan_column >= MAX_LENGTH) ? MAX_LENGTH - 1 : plan_column;
      if (!plan_written[col])
         queue_vector_write(col, draw_value());
      r.cmd           = CMD_MATRIX_ELEM;
      r.vector_index  = IDX_W'($urandom);  // don't care for matrix elements
      r.element_value = value;
      pending_requests.push_back(r);
      queued_total++;
      if (plan_column + 1 >= plan_length)
         plan_column = 0;
      else
         plan_column++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver. Random gap before each request, with back-to-back
   // stretches every fourth block of 80 requests.
   // ---------------------------------------------------------------------
   int unsigned sent_count = 0;
   int unsigned send_wait  = 0;
   logic        send_busy;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         send_busy = req_valid;
         if (req_valid && !req_stall) begin
            accumulate_request(req_data);
            sent_count++;
            send_wait = ((sent_count / 80) % 4 == 3) ? 0 : $urandom_range(0, MAX_WAIT);
            send_busy = 1'b0;
         end
         // a stalled request stays on the bus untouched
         if (!send_busy) begin
            if (send_wait > 0) begin
               send_wait--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               req_data  <= pending_requests.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor and checker. Random stall after each row, stall-free
   // stretches, and a few long hold-offs so the op queue fills and req_stall
   // gets exercised.
   // ---------------------------------------------------------------------
   int unsigned rows_seen      = 0;
   int unsigned stall_left     = 0;
   int unsigned hold_left      = 0;
   int unsigned mismatch_count = 0;

   task automatic check_row(rsp_type got);
      rsp_type want;
      if (expected_rows.size() == 0) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("row result with none expected: dot %h row %0d",
                     got.dot_product, got.row_number);
         mismatch_count++;
         return;
      end
      want = expected_rows.pop_front();
      if (got.dot_product !== want.dot_product || got.row_number !== want.row_number) begin
         if (mismatch_count < REPORT_LIMIT)
            $display("row mismatch: expected dot %h row %0d, got dot %h row %0d",
                     want.dot_product, want.row_number, got.dot_product, got.row_number);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_row(rsp_data);
            rows_seen++;
            if (rows_seen == 20 || rows_seen == 90 || rows_seen == 160)
               hold_left = HOLD_CYCLES;
            stall_left = ((rows_seen / 50) % 3 == 2) ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         if (hold_left > 0)
            hold_left--;
         rsp_stall <= (stall_left > 0) || (hold_left > 0);
      end
   end

   // watchdog: too long without any handshake means the block is stuck
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus sequencing
   // ---------------------------------------------------------------------

   // wait until every queued request is taken, every row is back and the
   // pipeline has had time to finish any partial-row work
   task automatic settle();
      while (sent_count != queued_total)
         @(posedge clock);
      while (expected_rows.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // only called while idle; counters and sum are kept across the write
   task automatic write_length(logic [LEN_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      length_reg  = value;
      plan_length = effective_length(value);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int unsigned directed_total;
      int unsigned phase_items;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two-column rows with the extreme Q7.8 values
      write_length(2);
      queue_vector_write(0, 16'h7FFF);
      queue_vector_write(1, 16'h8000);
      queue_vector_write(31, 16'h0001);
      queue_matrix_element(16'h7FFF);
      queue_matrix_element(16'h8000);   // max positive row sum
      queue_matrix_element(16'h8000);
      queue_matrix_element(16'h7FFF);   // most negative row sum
      queue_matrix_element(16'h0000);
      queue_vector_write(1, 16'hFFFF);  // vector write in the middle of a row
      queue_matrix_element(16'hFFFF);
      settle();

      // single-column rows
      write_length(1);
      queue_matrix_element(16'h8000);
      queue_matrix_element(16'h7FFF);
      settle();

      // length zero acts as one
      write_length(0);
      queue_matrix_element(16'h1234);
      settle();

      // oversize length saturates, then shrink it under a partial row
      write_length(63);
      repeat (6) queue_matrix_element(draw_value());
      settle();
      write_length(3);
      queue_matrix_element(16'h0100);
      settle();
      directed_total = queued_total;

      // random phases; most first set a new length, some keep the current one
      while (queued_total < directed_total + RANDOM_ITEMS) begin
         settle();
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: write_length(LEN_W'($urandom_range(1, 6)));
            6: write_length(LEN_W'(MAX_LENGTH));
            7: write_length(LEN_W'($urandom_range(7, MAX_LENGTH - 1)));
            8: write_length(LEN_W'($urandom_range(0, 1) == 0 ? 0
                                   : $urandom_range(MAX_LENGTH + 1, 63)));
            default: ;  // keep the current length
         endcase
         phase_items = $urandom_range(20, 60);
         repeat (phase_items) begin
            if ($urandom_range(0, 9) == 0)
               queue_vector_write($urandom_range(0, MAX_LENGTH - 1), draw_value());
            else
               queue_matrix_element(draw_value());
         end
      end
      settle();

      if (mismatch_count == 0 && expected_rows.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

[filelist.f]
design/mvm_pkg.sv
design/mvm_front.sv
design/mvm_queue.sv
design/mvm_back.sv
design/matrix_vector_multiply_core.sv
design/mvm_checker.sv
dv/matrix_vector_multiply_core_test.sv
